// ===== hw/rtl/at_response_line_classifier_defines.svh =====
// Assertion macros used by the classifier checker.
`ifndef AT_RESPONSE_LINE_CLASSIFIER_DEFINES_SVH
`define AT_RESPONSE_LINE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication on the rising edge of clock, off during reset.
`define ATRLC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("atrlc assertion failed");

// Next-cycle implication on the rising edge of clock, off during reset.
`define ATRLC_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("atrlc assertion failed");

`endif

// ===== hw/rtl/atrlc_pkg.sv =====
// Types, constants and helper functions of the AT response line classifier.
package atrlc_pkg;

   localparam int LINE_MAX_DEF  = 32;
   localparam int LINES_MAX_DEF = 16;

   localparam int KW_NUM   = 7;
   localparam int KW_CHARS = 11;

   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_QUOTE = 8'h22;
   localparam logic [7:0] CHR_COMMA = 8'h2C;
   localparam logic [7:0] CHR_SEMI  = 8'h3B;
   localparam logic [7:0] CHR_GT    = 8'h3E;
   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] CHR_C     = 8'h43;
   localparam logic [7:0] CHR_M     = 8'h4D;
   localparam logic [7:0] CHR_E     = 8'h45;
   localparam logic [7:0] CHR_S     = 8'h53;

   // Keyword text, last character in element 0.
   localparam logic [KW_CHARS-1:0][7:0] KW_TEXT [KW_NUM] = '{
      "OK", "ERROR", "BUSY", "NO ANSWER", "NO CARRIER", "NO DIALTONE", "RING"
   };
   localparam logic [3:0] KW_LEN [KW_NUM] = '{4'd2, 4'd5, 4'd4, 4'd9, 4'd10, 4'd11, 4'd4};

   localparam int RSP_DEPTH = 2;

   typedef enum logic [1:0] {
      MODE_DELIM,
      MODE_LINE,
      MODE_PROMPT
   } mode_type;

   typedef enum logic [3:0] {
      KIND_DATA        = 4'd0,
      KIND_OK          = 4'd1,
      KIND_ERROR       = 4'd2,
      KIND_BUSY        = 4'd3,
      KIND_NO_ANSWER   = 4'd4,
      KIND_NO_CARRIER  = 4'd5,
      KIND_NO_DIALTONE = 4'd6,
      KIND_RING        = 4'd7,
      KIND_CME         = 4'd8,
      KIND_CMS         = 4'd9
   } kind_type;

   // Line scanner to response tracker.
   typedef struct packed {
      logic       close;
      logic       prompt;
      kind_type   kind;
      logic [4:0] fields;
      logic [5:0] length;
      logic       truncated;
   } line_evt_type;

   typedef struct packed {
      kind_type   line_kind;
      logic [4:0] field_count;
      logic [5:0] line_length;
      logic [3:0] line_index;
      logic       ends_response;
      logic       final_status;
      logic [3:0] call_flags;
      logic       is_prompt;
      logic       overflow;
   } rsp_word_type;

   function automatic logic is_delim(input logic [7:0] c);
      case (c) inside
         CHR_QUOTE, CHR_SEMI, CHR_COMMA, CHR_SPACE, CHR_TAB: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Does character c match keyword k at position pos.
   function automatic logic kw_hit(input logic [2:0] k, input logic [7:0] pos,
                                   input logic [7:0] c);
      logic [3:0] idx;
      idx = '0;
      if (pos >= 8'(KW_LEN[k])) return 1'b0;
      idx = 4'(KW_LEN[k] - 4'd1 - 4'(pos));
      return KW_TEXT[k][idx] == c;
   endfunction

endpackage

// ===== hw/rtl/atrlc_stream_if.sv =====
// Request and response channel interfaces of the classifier.
interface atrlc_req_if ();
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface atrlc_rsp_if ();
   logic       valid;
   logic       ready;
   logic [3:0] line_kind;
   logic [4:0] field_count;
   logic [5:0] line_length;
   logic [3:0] line_index;
   logic       ends_response;
   logic       final_status;
   logic [3:0] call_flags;
   logic       is_prompt;
   logic       overflow;

   modport source (output valid, output line_kind, output field_count, output line_length,
                   output line_index, output ends_response, output final_status,
                   output call_flags, output is_prompt, output overflow, input ready);
   modport sink (input valid, input line_kind, input field_count, input line_length,
                 input line_index, input ends_response, input final_status,
                 input call_flags, input is_prompt, input overflow, output ready);
endinterface

// ===== hw/rtl/at_response_line_classifier.sv =====
// AT response line classifier: top level.
// req_chan carries one received modem byte per word (rx_byte); zero bytes are
// dropped silently. rsp_chan carries one word for every LF that closes a line
// and for every '>' prompt seen inside a line; other bytes give no word.
// A byte accepted on req_chan is held in the input register and classified
// from there; any result is written into the result queue and is shown on
// rsp_chan from the head of that queue. One byte is taken every cycle while
// the sink keeps up; the limit is the single-pass scan of the byte held in
// the input register.
// Results go through a two-word queue, so bytes keep flowing while one result
// waits. With two results waiting, the byte in the input register stalls and
// req ready drops until the sink takes a word.
// Synchronous reset returns the parser to delimiter mode, marks the response
// as closed, clears call flags and line count, and empties the queue and the
// input register.
module at_response_line_classifier import atrlc_pkg::*; #(
   parameter int LINE_MAX  = LINE_MAX_DEF,
   parameter int LINES_MAX = LINES_MAX_DEF
) (
   input  logic            clock,
   input  logic            reset,
   atrlc_req_if.sink       req_chan,
   atrlc_rsp_if.source     rsp_chan
);

   logic [7:0]   byte_ff, byte_in;
   logic         byte_vld_ff, byte_vld_in;
   logic         q_full;
   logic         go;
   logic         req_take;
   line_evt_type evt;
   rsp_word_type res_word;
   rsp_word_type out_word;

   assign go             = byte_vld_ff && !q_full;
   assign req_chan.ready = !byte_vld_ff || go;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      byte_in     = req_take ? req_chan.rx_byte : byte_ff;
      byte_vld_in = req_take ? 1'b1 : (go ? 1'b0 : byte_vld_ff);
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) byte_vld_ff <= 1'b0;
      else byte_vld_ff <= byte_vld_in;
   end

   atrlc_line_scan #(
      .LINE_MAX (LINE_MAX)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .en      (go),
      .rx_byte (byte_ff),
      .evt     (evt)
   );

   atrlc_resp_track #(
      .LINES_MAX (LINES_MAX)
   ) u_track (
      .clock (clock),
      .reset (reset),
      .evt   (evt),
      .word  (res_word)
   );

   atrlc_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (evt.close || evt.prompt),
      .push_word (res_word),
      .full      (q_full),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_word  (out_word)
   );

   assign rsp_chan.line_kind     = out_word.line_kind;
   assign rsp_chan.field_count   = out_word.field_count;
   assign rsp_chan.line_length   = out_word.line_length;
   assign rsp_chan.line_index    = out_word.line_index;
   assign rsp_chan.ends_response = out_word.ends_response;
   assign rsp_chan.final_status  = out_word.final_status;
   assign rsp_chan.call_flags    = out_word.call_flags;
   assign rsp_chan.is_prompt     = out_word.is_prompt;
   assign rsp_chan.overflow      = out_word.overflow;

endmodule

// ===== hw/rtl/atrlc_line_scan.sv =====
// Per-character line scanner: parse mode, keyword and +CME/+CMS match, field count.
module atrlc_line_scan import atrlc_pkg::*; #(
   parameter int LINE_MAX = LINE_MAX_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic [7:0]   rx_byte,
   output line_evt_type evt
);

   localparam int LEN_W = $clog2(LINE_MAX + 1);

   mode_type           mode_ff, mode_in;
   logic [LEN_W-1:0]   kept_ff, kept_in;
   logic [KW_NUM-1:0]  cand_ff, cand_in;
   logic [1:0]         plus_ff, plus_in;
   logic [1:0]         cmecms_ff, cmecms_in;
   logic [4:0]         fields_ff, fields_in;
   logic               infield_ff, infield_in;
   logic               trunc_ff, trunc_in;

   logic               active;
   logic               start_line;
   logic               keep;
   logic               close_hit;
   logic               prompt_hit;
   logic [KW_NUM-1:0]  hits;
   kind_type           kw_kind;

   assign active = en && (rx_byte != 8'h00);

   always_comb begin
      mode_in = mode_ff;
      if (active) begin
         unique case (mode_ff)
            MODE_LINE: begin
               if (rx_byte == CHR_GT) mode_in = MODE_PROMPT;
               else if (rx_byte == CHR_LF) mode_in = MODE_DELIM;
            end
            MODE_PROMPT: begin
               if (rx_byte == CHR_CR) mode_in = MODE_DELIM;
            end
            MODE_DELIM: begin
               if (rx_byte == CHR_LF) mode_in = MODE_LINE;
            end
            default: mode_in = MODE_DELIM;
         endcase
      end
   end

   always_comb begin
      start_line = 1'b0;
      keep       = 1'b0;
      close_hit  = 1'b0;
      prompt_hit = 1'b0;
      if (active) begin
         unique case (mode_ff)
            MODE_LINE: begin
               if (rx_byte == CHR_GT) begin
                  prompt_hit = 1'b1;
                  start_line = 1'b1;
               end else if (rx_byte == CHR_LF) begin
                  close_hit  = 1'b1;
                  start_line = 1'b1;
               end else if (rx_byte != CHR_CR) begin
                  keep = 1'b1;
               end
            end
            MODE_DELIM: start_line = (rx_byte == CHR_LF);
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < KW_NUM; k++) begin
         hits[k] = kw_hit(3'(k), 8'(kept_ff), rx_byte);
      end
   end

   always_comb begin
      kept_in    = kept_ff;
      cand_in    = cand_ff;
      plus_in    = plus_ff;
      cmecms_in  = cmecms_ff;
      fields_in  = fields_ff;
      infield_in = infield_ff;
      trunc_in   = trunc_ff;
      if (start_line) begin
         kept_in    = '0;
         cand_in    = '1;
         plus_in    = '0;
         cmecms_in  = '0;
         fields_in  = '0;
         infield_in = 1'b0;
         trunc_in   = 1'b0;
      end else if (keep) begin
         if (kept_ff >= LEN_W'(LINE_MAX)) begin
            trunc_in = 1'b1;
         end else begin
            cand_in = cand_ff & hits;
            if (plus_ff == 2'd3) begin
               if (rx_byte == CHR_E) cmecms_in[0] = 1'b1;
               if (rx_byte == CHR_S) cmecms_in[1] = 1'b1;
            end
            if (rx_byte == CHR_PLUS) plus_in = 2'd1;
            else if (plus_ff == 2'd1 && rx_byte == CHR_C) plus_in = 2'd2;
            else if (plus_ff == 2'd2 && rx_byte == CHR_M) plus_in = 2'd3;
            else plus_in = 2'd0;
            if (is_delim(rx_byte)) begin
               infield_in = 1'b0;
            end else if (!infield_ff) begin
               infield_in = 1'b1;
               if (fields_ff != 5'd31) fields_in = fields_ff + 5'd1;
            end
            kept_in = kept_ff + LEN_W'(1);
         end
      end
   end

   // Line class from the state before the closing LF; first keyword wins.
   always_comb begin
      kw_kind = KIND_DATA;
      for (int k = KW_NUM - 1; k >= 0; k--) begin
         if (cand_ff[k] && kept_ff == LEN_W'(KW_LEN[k])) kw_kind = kind_type'(4'(k + 1));
      end
   end

   always_comb begin
      evt.close     = close_hit;
      evt.prompt    = prompt_hit;
      evt.kind      = kw_kind;
      evt.fields    = '0;
      evt.length    = 6'(kept_ff);
      evt.truncated = trunc_ff;
      if (kw_kind == KIND_DATA) begin
         evt.fields = fields_ff;
         if (cmecms_ff[0]) evt.kind = KIND_CME;
         else if (cmecms_ff[1]) evt.kind = KIND_CMS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_DELIM;
         kept_ff    <= '0;
         cand_ff    <= '1;
         plus_ff    <= '0;
         cmecms_ff  <= '0;
         fields_ff  <= '0;
         infield_ff <= 1'b0;
         trunc_ff   <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         kept_ff    <= kept_in;
         cand_ff    <= cand_in;
         plus_ff    <= plus_in;
         cmecms_ff  <= cmecms_in;
         fields_ff  <= fields_in;
         infield_ff <= infield_in;
         trunc_ff   <= trunc_in;
      end
   end

endmodule

// ===== hw/rtl/atrlc_resp_track.sv =====
// Response tracker: line index, call flags, verdict; builds the result word.
module atrlc_resp_track import atrlc_pkg::*; #(
   parameter int LINES_MAX = LINES_MAX_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  line_evt_type evt,
   output rsp_word_type word
);

   localparam int IDX_CAP = (LINES_MAX - 1 > 15) ? 15 : LINES_MAX - 1;

   logic [3:0] flags_ff, flags_in;
   logic [3:0] lines_ff, lines_in;
   logic       verdict_ff, verdict_in;
   logic       closed_ff, closed_in;

   logic [3:0] flags_base;
   logic [3:0] lines_base;
   logic       verdict_base;
   logic       ends;

   always_comb begin
      flags_base   = closed_ff ? 4'd0 : flags_ff;
      lines_base   = closed_ff ? 4'd0 : lines_ff;
      verdict_base = closed_ff ? 1'b0 : verdict_ff;

      flags_in   = flags_ff;
      lines_in   = lines_ff;
      verdict_in = verdict_ff;
      closed_in  = closed_ff;
      ends       = 1'b0;

      if (evt.close) begin
         flags_in   = flags_base;
         verdict_in = verdict_base;
         case (evt.kind)
            KIND_OK: begin
               verdict_in = 1'b1;
               ends       = 1'b1;
            end
            KIND_ERROR: begin
               verdict_in = 1'b0;
               ends       = 1'b1;
            end
            KIND_BUSY:        flags_in = flags_base | 4'b0001;
            KIND_NO_ANSWER:   flags_in = flags_base | 4'b0010;
            KIND_NO_CARRIER:  flags_in = flags_base | 4'b0100;
            KIND_NO_DIALTONE: flags_in = flags_base | 4'b1000;
            KIND_CME, KIND_CMS: ends = 1'b1;
            default: ;
         endcase
         lines_in  = (lines_base < 4'(IDX_CAP)) ? lines_base + 4'd1 : lines_base;
         closed_in = ends;
      end
   end

   always_comb begin
      word = '0;
      if (evt.prompt) begin
         word.call_flags = flags_ff;
         word.is_prompt  = 1'b1;
      end else begin
         word.line_kind     = evt.kind;
         word.field_count   = evt.fields;
         word.line_length   = evt.length;
         word.line_index    = lines_base;
         word.ends_response = ends;
         word.final_status  = !verdict_in;
         word.call_flags    = flags_in;
         word.overflow      = evt.truncated;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff   <= '0;
         lines_ff   <= '0;
         verdict_ff <= 1'b0;
         closed_ff  <= 1'b1;
      end else begin
         flags_ff   <= flags_in;
         lines_ff   <= lines_in;
         verdict_ff <= verdict_in;
         closed_ff  <= closed_in;
      end
   end

endmodule

// ===== hw/rtl/atrlc_rsp_fifo.sv =====
// Two-word result queue between the classifier and the response channel.
module atrlc_rsp_fifo import atrlc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_word_type push_word,
   output logic         full,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_word_type out_word
);

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   rsp_word_type     word_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign full      = (count_ff == CNT_W'(RSP_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_word  = word_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) word_ff[wr_ptr_ff] <= push_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/atrlc_checker.sv =====
// Port-level checker for the AT response line classifier, with its bind.
`include "at_response_line_classifier_defines.svh"

module atrlc_checker import atrlc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_kind,
   input logic [4:0] rsp_fields,
   input logic [5:0] rsp_length,
   input logic [3:0] rsp_index,
   input logic       rsp_ends,
   input logic       rsp_final,
   input logic [3:0] rsp_flags,
   input logic       rsp_is_prompt,
   input logic       rsp_overflow
);

   logic [27:0] rsp_bits;

   assign rsp_bits = {rsp_kind, rsp_fields, rsp_length, rsp_index, rsp_ends, rsp_final,
                      rsp_flags, rsp_is_prompt, rsp_overflow};

   `ATRLC_ASSERT_NXT(a_hold_valid, rsp_valid && !rsp_ready, rsp_valid)
   `ATRLC_ASSERT_NXT(a_hold_word, rsp_valid && !rsp_ready, $stable(rsp_bits))
   `ATRLC_ASSERT_IMP(a_prompt_clean, rsp_valid && rsp_is_prompt, rsp_kind == KIND_DATA && rsp_fields == 5'd0 && rsp_length == 6'd0 && !rsp_ends && !rsp_overflow)
   `ATRLC_ASSERT_IMP(a_ends_kind, rsp_valid && rsp_ends, rsp_kind == KIND_OK || rsp_kind == KIND_ERROR || rsp_kind == KIND_CME || rsp_kind == KIND_CMS)
   `ATRLC_ASSERT_IMP(a_ok_status, rsp_valid && !rsp_is_prompt && rsp_kind == KIND_OK, !rsp_final && rsp_fields == 5'd0)

endmodule

bind at_response_line_classifier atrlc_checker u_atrlc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_kind      (rsp_chan.line_kind),
   .rsp_fields    (rsp_chan.field_count),
   .rsp_length    (rsp_chan.line_length),
   .rsp_index     (rsp_chan.line_index),
   .rsp_ends      (rsp_chan.ends_response),
   .rsp_final     (rsp_chan.final_status),
   .rsp_flags     (rsp_chan.call_flags),
   .rsp_is_prompt (rsp_chan.is_prompt),
   .rsp_overflow  (rsp_chan.overflow)
);

// ===== sim/at_response_line_classifier_tb.sv =====
// Testbench for the AT response line classifier: byte streams checked against a line predictor.
`timescale 1ns / 1ps

module at_response_line_classifier_tb;
   import atrlc_pkg::*;

   localparam int LINE_LIMIT   = LINE_MAX_DEF;
   localparam int INDEX_CAP    = (LINES_MAX_DEF - 1 > 15) ? 15 : LINES_MAX_DEF - 1;
   localparam int RANDOM_BYTES = 650;
   localparam int PRINT_LIMIT  = 40;

   logic clock = 1'b0;
   logic reset;

   atrlc_req_if req_chan ();
   atrlc_rsp_if rsp_chan ();

   at_response_line_classifier u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted parser state
   mode_type   scan_mode;
   logic [7:0] kept_len;
   logic [6:0] kw_alive;
   logic [1:0] plus_step;
   logic [1:0] cm_seen;
   logic [4:0] field_cnt;
   logic       in_field;
   logic [3:0] line_cnt;
   logic [3:0] flag_acc;
   logic       verdict_ok;
   logic       resp_done;
   logic       clipped;

   rsp_word_type pending_lines[$];

   int err_count   = 0;
   int byte_count  = 0;
   int src_gap_max = 0;
   int snk_gap_max = 0;
   int sink_hold   = 0;
   int stall_left  = 0;

   function automatic int kw_len(input int k);
      case (k)
         0: return 2;
         1: return 5;
         2: return 4;
         3: return 9;
         4: return 10;
         5: return 11;
         default: return 4;
      endcase
   endfunction

   function automatic logic [7:0] kw_char(input int k, input int pos);
      logic [87:0] txt;
      txt = '0;
      case (k)
         0: txt = "OK";
         1: txt = "ERROR";
         2: txt = "BUSY";
         3: txt = "NO ANSWER";
         4: txt = "NO CARRIER";
         5: txt = "NO DIALTONE";
         default: txt = "RING";
      endcase
      return txt[(kw_len(k) - 1 - pos) * 8 +: 8];
   endfunction

   function automatic logic is_separator(input logic [7:0] c);
      return c == CHR_QUOTE || c == CHR_SEMI || c == CHR_COMMA || c == CHR_SPACE
         || c == CHR_TAB;
   endfunction

   task automatic restart_line();
      kept_len  = '0;
      kw_alive  = '1;
      plus_step = '0;
      cm_seen   = '0;
      field_cnt = '0;
      in_field  = 1'b0;
      clipped   = 1'b0;
   endtask

   task automatic scan_char(input logic [7:0] c);
      if (kept_len >= LINE_LIMIT) begin
         clipped = 1'b1;
         return;
      end
      for (int k = 0; k < 7; k++) begin
         if (kept_len >= kw_len(k) || kw_char(k, kept_len) != c) kw_alive[k] = 1'b0;
      end
      if (plus_step == 2'd3) begin
         if (c == CHR_E) cm_seen[0] = 1'b1;
         if (c == CHR_S) cm_seen[1] = 1'b1;
      end
      if (c == CHR_PLUS) plus_step = 2'd1;
      else if (plus_step == 2'd1 && c == CHR_C) plus_step = 2'd2;
      else if (plus_step == 2'd2 && c == CHR_M) plus_step = 2'd3;
      else plus_step = 2'd0;
      if (is_separator(c)) begin
         in_field = 1'b0;
      end else if (!in_field) begin
         in_field = 1'b1;
         if (field_cnt != 5'd31) field_cnt++;
      end
      kept_len++;
   endtask

   task automatic finish_line();
      rsp_word_type w;
      kind_type     kind;
      logic         ends;
      w    = '0;
      kind = KIND_DATA;
      ends = 1'b0;
      if (resp_done) begin
         flag_acc   = '0;
         line_cnt   = '0;
         verdict_ok = 1'b0;
         resp_done  = 1'b0;
      end
      for (int k = 6; k >= 0; k--) begin
         if (kw_alive[k] && kept_len == kw_len(k)) kind = kind_type'(k + 1);
      end
      if (kind == KIND_DATA) begin
         if (cm_seen[0]) kind = KIND_CME;
         else if (cm_seen[1]) kind = KIND_CMS;
         w.field_count = field_cnt;
      end
      case (kind)
         KIND_OK: begin
            verdict_ok = 1'b1;
            ends = 1'b1;
         end
         KIND_ERROR: begin
            verdict_ok = 1'b0;
            ends = 1'b1;
         end
         KIND_BUSY:        flag_acc[0] = 1'b1;
         KIND_NO_ANSWER:   flag_acc[1] = 1'b1;
         KIND_NO_CARRIER:  flag_acc[2] = 1'b1;
         KIND_NO_DIALTONE: flag_acc[3] = 1'b1;
         KIND_CME, KIND_CMS: ends = 1'b1;
         default: ;
      endcase
      w.line_kind   = kind;
      w.line_length = kept_len[5:0];
      w.line_index  = (line_cnt > 4'(INDEX_CAP)) ? 4'(INDEX_CAP) : line_cnt;
      if (line_cnt < 4'(INDEX_CAP)) line_cnt++;
      if (ends) resp_done = 1'b1;
      w.ends_response = ends;
      w.final_status  = !verdict_ok;
      w.call_flags    = flag_acc;
      w.overflow      = clipped;
      pending_lines.push_back(w);
      restart_line();
      scan_mode = MODE_DELIM;
   endtask

   task automatic classify_byte(input logic [7:0] c);
      rsp_word_type w;
      w = '0;
      if (c == 8'h00) return;
      case (scan_mode)
         MODE_LINE: begin
            if (c == CHR_GT) begin
               w.call_flags = flag_acc;
               w.is_prompt  = 1'b1;
               pending_lines.push_back(w);
               restart_line();
               scan_mode = MODE_PROMPT;
            end else if (c == CHR_LF) begin
               finish_line();
            end else if (c != CHR_CR) begin
               scan_char(c);
            end
         end
         MODE_PROMPT: begin
            if (c == CHR_CR) scan_mode = MODE_DELIM;
         end
         default: begin
            if (c == CHR_LF) begin
               restart_line();
               scan_mode = MODE_LINE;
            end
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      err_count++;
      if (err_count <= PRINT_LIMIT)
         $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
   endtask

   task automatic check_word();
      rsp_word_type got;
      rsp_word_type want;
      got.line_kind     = kind_type'(rsp_chan.line_kind);
      got.field_count   = rsp_chan.field_count;
      got.line_length   = rsp_chan.line_length;
      got.line_index    = rsp_chan.line_index;
      got.ends_response = rsp_chan.ends_response;
      got.final_status  = rsp_chan.final_status;
      got.call_flags    = rsp_chan.call_flags;
      got.is_prompt     = rsp_chan.is_prompt;
      got.overflow      = rsp_chan.overflow;
      if (pending_lines.size() == 0) begin
         report_mismatch("word with nothing pending, line_kind", got.line_kind, -1);
         return;
      end
      want = pending_lines.pop_front();
      if (got.line_kind != want.line_kind)
         report_mismatch("line_kind", got.line_kind, want.line_kind);
      if (got.field_count != want.field_count)
         report_mismatch("field_count", got.field_count, want.field_count);
      if (got.line_length != want.line_length)
         report_mismatch("line_length", got.line_length, want.line_length);
      if (got.line_index != want.line_index)
         report_mismatch("line_index", got.line_index, want.line_index);
      if (got.ends_response != want.ends_response)
         report_mismatch("ends_response", got.ends_response, want.ends_response);
      if (got.final_status != want.final_status)
         report_mismatch("final_status", got.final_status, want.final_status);
      if (got.call_flags != want.call_flags)
         report_mismatch("call_flags", got.call_flags, want.call_flags);
      if (got.is_prompt != want.is_prompt)
         report_mismatch("is_prompt", got.is_prompt, want.is_prompt);
      if (got.overflow != want.overflow)
         report_mismatch("overflow", got.overflow, want.overflow);
   endtask

   // result sink: random stalls per word, plus a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            check_word();
            stall_left = $urandom_range(0, snk_gap_max);
         end
         if (sink_hold > 0) begin
            rsp_chan.ready <= 1'b0;
            sink_hold--;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] c);
      int gap;
      gap = $urandom_range(0, src_gap_max);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= c;
      do @(posedge clock); while (!req_chan.ready);
      classify_byte(c);
      if (c != 8'h00) byte_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_line_start();
      send_byte(CHR_CR);
      send_byte(CHR_LF);
   endtask

   task automatic send_line_end();
      send_byte(CHR_CR);
      send_byte(CHR_LF);
   endtask

   task automatic send_line(input string s);
      send_line_start();
      send_text(s);
      send_line_end();
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_lines.size() != 0);
   endtask

   function automatic logic [7:0] random_line_char();
      logic [7:0] c;
      c = "A";
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: c = CHR_QUOTE;
               1: c = CHR_SEMI;
               2: c = CHR_COMMA;
               3: c = CHR_SPACE;
               default: c = CHR_TAB;
            endcase
         end
         1: c = CHR_PLUS;
         2: begin
            case ($urandom_range(0, 3))
               0: c = CHR_C;
               1: c = CHR_M;
               2: c = CHR_E;
               default: c = CHR_S;
            endcase
         end
         3: begin
            c = 8'($urandom_range(1, 255));
            if (c == CHR_LF || c == CHR_GT) c = CHR_SPACE;
         end
         4: c = $urandom_range(0, 1) ? 8'h00 : CHR_CR;
         5: c = 8'($urandom_range(8'h30, 8'h39));
         default: c = 8'($urandom_range(8'h41, 8'h5A));
      endcase
      return c;
   endfunction

   task automatic send_random_line();
      int pick;
      int k;
      int n;
      int variant;
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         if ($urandom_range(0, 3) != 0) send_byte(CHR_CR);
         send_byte(CHR_LF);
      end
      if (pick < 35) begin
         k = $urandom_range(0, 6);
         variant = $urandom_range(0, 5);
         n = (variant == 0) ? kw_len(k) - 1 : kw_len(k);
         for (int p = 0; p < n; p++) send_byte(kw_char(k, p));
         if (variant == 1) send_byte(random_line_char());
      end else if (pick < 50) begin
         repeat ($urandom_range(0, 3)) send_byte(random_line_char());
         send_text("+CM");
         send_byte($urandom_range(0, 1) ? CHR_E : CHR_S);
         repeat ($urandom_range(0, 12)) send_byte(random_line_char());
      end else if (pick < 78) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 45) : $urandom_range(0, 10);
         repeat (n) send_byte(random_line_char());
      end else if (pick < 85) begin
         repeat ($urandom_range(0, 5)) send_byte(random_line_char());
         send_byte(CHR_GT);
         repeat ($urandom_range(0, 4)) send_byte(random_line_char());
         send_byte(CHR_CR);
         return;
      end else begin
         repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
         return;
      end
      if ($urandom_range(0, 3) != 0) send_byte(CHR_CR);
      send_byte(CHR_LF);
   endtask

   task automatic test_keywords();
      src_gap_max = 6;
      snk_gap_max = 6;
      // noise and '>' before any LF are ignored in delimiter mode
      send_text("AT>");
      send_byte(8'h00);
      send_line("RING");
      send_line("BUSY");
      send_line("NO ANSWER");
      send_line("NO CARRIER");
      send_line("NO DIALTONE");
      send_line("ERROR");
      send_line("OKAY");
      send_line("ERRO");
      send_line("OK");
      wait_drained();
   endtask

   task automatic test_error_codes();
      src_gap_max = 0;
      snk_gap_max = 6;
      send_line("+CME ERROR: 10");
      send_line("+CMS ERROR: 500");
      send_line("+CMS+CME");
      send_line("a+C+CMx+CMS");
      send_line("OK");
      wait_drained();
   endtask

   task automatic test_fields_and_prompt();
      src_gap_max = 6;
      snk_gap_max = 0;
      send_line("");
      send_line(" ");
      send_line_start();
      send_text("\"ab\";c,,d e");
      send_byte(CHR_TAB);
      send_text("f");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_line_end();
      send_line_start();
      send_text("AT+CMGS");
      send_byte(CHR_GT);
      send_text("x>y");
      send_byte(CHR_LF);
      send_byte(CHR_CR);
      send_line("OK");
      wait_drained();
   endtask

   task automatic test_long_lines();
      src_gap_max = 0;
      snk_gap_max = 0;
      send_line_start();
      repeat (20) send_text("a ");
      send_line_end();
      send_line_start();
      send_text("OK");
      repeat (30) send_byte("x");
      send_line_end();
      send_line_start();
      send_text("OK");
      repeat (40) send_byte("x");
      send_line_end();
      send_line("ERROR");
      wait_drained();
   endtask

   task automatic test_line_index();
      src_gap_max = 6;
      snk_gap_max = 6;
      repeat (18) send_line("+X");
      send_line("NO CARRIER");
      send_line("OK");
      send_line("RING");
      wait_drained();
   endtask

   task automatic test_backpressure();
      src_gap_max = 0;
      snk_gap_max = 0;
      sink_hold = 120;
      repeat (12) send_line("BUSY");
      send_line("ERROR");
      wait_drained();
   endtask

   task automatic test_random();
      int   stop_at;
      logic held;
      stop_at = byte_count + RANDOM_BYTES;
      held = 1'b0;
      while (byte_count < stop_at) begin
         if ($urandom_range(0, 19) == 0) begin
            src_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
            snk_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
         end
         if (!held && byte_count > stop_at - RANDOM_BYTES / 2) begin
            sink_hold = 150;
            held = 1'b1;
         end
         send_random_line();
      end
      wait_drained();
   endtask

   initial begin
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= 8'h00;
      scan_mode  = MODE_DELIM;
      restart_line();
      line_cnt   = '0;
      flag_acc   = '0;
      verdict_ok = 1'b0;
      resp_done  = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_keywords();
      test_error_codes();
      test_fields_and_prompt();
      test_long_lines();
      test_line_index();
      test_backpressure();
      test_random();

      repeat (10) @(posedge clock);
      if (err_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== at_response_line_classifier.f =====
+incdir+hw/rtl
hw/rtl/atrlc_pkg.sv
hw/rtl/atrlc_stream_if.sv
hw/rtl/atrlc_line_scan.sv
hw/rtl/atrlc_resp_track.sv
hw/rtl/atrlc_rsp_fifo.sv
hw/rtl/at_response_line_classifier.sv
hw/rtl/atrlc_checker.sv
sim/at_response_line_classifier_tb.sv
